### design/cpfcd_pkg.sv
`default_nettype none

package cpfcd_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Request field widths
    localparam int ID_W        = 44;
    localparam int ID_NIBBLES  = 11;
    localparam int SLOT_W      = 6;
    localparam int RCNT_W      = 7;
    localparam int S_DATA_W    = 64;
    localparam int M_DATA_W    = 16;

    // Weighted sums stay below 1024 even for raw nibbles up to 15
    localparam int SUM_W       = 10;
    // floor(s * RECIP11 / 2^16) == floor(s / 11) for every s below 1024
    localparam int RECIP11     = 5958;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DUP      = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_BAD      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        F_IDLE,
        F_FIRST,
        F_SECOND,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_DONE
    } t_back_state;

    // One classified request handed from front to back
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [IDX_W-1:0] slot_idx;
        logic             slot_ok;
        logic [CNT_W-1:0] cnt;
        logic [3:0]       e1;
        logic [3:0]       e2;
        t_status          pre_status;
    } t_job;

    // Check digit from a weighted sum: 11 - (s mod 11), with 10 and 11 folded to 0
    function automatic logic [3:0] fold_mod11(input logic [SUM_W-1:0] s);
        logic [SUM_W+12:0] prod;
        logic [6:0]        q;
        logic [SUM_W-1:0]  r;
        logic [3:0]        d;
        prod = (SUM_W+13)'(s) * (SUM_W+13)'(RECIP11);
        q    = prod[SUM_W+12:16];
        r    = s - SUM_W'(q) * SUM_W'(11);
        if (r >= SUM_W'(11)) begin
            r = r - SUM_W'(11);
        end
        d = 4'd11 - r[3:0];
        if (d >= 4'd10) begin
            d = 4'd0;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

### design/cpfcd_front.sv
`default_nettype none

module cpfcd_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire [cpfcd_pkg::ID_W-1:0]    i_id,
    input  wire [cpfcd_pkg::SLOT_W-1:0]  i_slot,
    input  wire [cpfcd_pkg::RCNT_W-1:0]  i_count,
    input  wire                          i_q_full,
    output logic                         o_push,
    output cpfcd_pkg::t_job              o_job
);

    cpfcd_pkg::t_front_state r_state, n_state;

    logic [cpfcd_pkg::ID_W-1:0]  r_id;
    logic [cpfcd_pkg::IDX_W-1:0] r_slot_idx;
    logic                        r_slot_ok;
    logic [cpfcd_pkg::CNT_W-1:0] r_cnt;
    logic                        r_bad;
    logic [cpfcd_pkg::SUM_W-1:0] r_s1;
    logic [cpfcd_pkg::SUM_W-1:0] r_s2;
    logic [3:0]                  r_e1;
    logic [3:0]                  r_e2;

    logic [3:0]                  w_dig [cpfcd_pkg::ID_NIBBLES];
    logic [cpfcd_pkg::SUM_W-1:0] w_s1;
    logic [cpfcd_pkg::SUM_W-1:0] w_s2;
    logic                        w_bad;
    logic                        w_accept;
    cpfcd_pkg::t_status          w_pre;

    // Split the ID into digits, first digit at index 0
    always_comb begin
        for (int i = 0; i < cpfcd_pkg::ID_NIBBLES; i++) begin
            w_dig[i] = i_id[(cpfcd_pkg::ID_NIBBLES-1-i)*4 +: 4];
        end
    end

    // Weighted sums over the first nine digits and the bad digit flag
    always_comb begin
        w_s1  = '0;
        w_s2  = '0;
        w_bad = 1'b0;
        for (int i = 0; i < cpfcd_pkg::ID_NIBBLES - 2; i++) begin
            w_s1 = w_s1 + cpfcd_pkg::SUM_W'(w_dig[i]) * cpfcd_pkg::SUM_W'(10 - i);
            w_s2 = w_s2 + cpfcd_pkg::SUM_W'(w_dig[i]) * cpfcd_pkg::SUM_W'(11 - i);
        end
        for (int i = 0; i < cpfcd_pkg::ID_NIBBLES; i++) begin
            if (w_dig[i] > 4'd9) begin
                w_bad = 1'b1;
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cpfcd_pkg::F_IDLE:   if (i_valid) n_state = cpfcd_pkg::F_FIRST;
            cpfcd_pkg::F_FIRST:  n_state = cpfcd_pkg::F_SECOND;
            cpfcd_pkg::F_SECOND: n_state = cpfcd_pkg::F_PUSH;
            cpfcd_pkg::F_PUSH:   if (!i_q_full) n_state = cpfcd_pkg::F_IDLE;
            default:             n_state = cpfcd_pkg::F_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_ready  = 1'b0;
        o_push   = 1'b0;
        case (r_state)
            cpfcd_pkg::F_IDLE: o_ready = 1'b1;
            cpfcd_pkg::F_PUSH: o_push  = !i_q_full;
            default: begin
                o_ready = 1'b0;
                o_push  = 1'b0;
            end
        endcase
        w_accept = o_ready && i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cpfcd_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the request and work out the two check digits
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_id       <= i_id;
            r_slot_idx <= cpfcd_pkg::IDX_W'(i_slot);
            r_slot_ok  <= (32'(i_slot) < cpfcd_pkg::TABLE_DEPTH);
            if (32'(i_count) > cpfcd_pkg::TABLE_DEPTH) begin
                r_cnt <= cpfcd_pkg::CNT_W'(cpfcd_pkg::TABLE_DEPTH);
            end else begin
                r_cnt <= cpfcd_pkg::CNT_W'(i_count);
            end
            r_bad <= w_bad;
            r_s1  <= w_s1;
            r_s2  <= w_s2;
        end
        if (r_state == cpfcd_pkg::F_FIRST) begin
            r_e1 <= cpfcd_pkg::fold_mod11(r_s1);
        end
        if (r_state == cpfcd_pkg::F_SECOND) begin
            r_e2 <= cpfcd_pkg::fold_mod11(r_s2 + cpfcd_pkg::SUM_W'({r_e1, 1'b0}));
        end
    end

    // Classify everything but the duplicate case
    always_comb begin
        if (r_bad) begin
            w_pre = cpfcd_pkg::ST_BAD;
        end else if (r_id[7:4] != r_e1 || r_id[3:0] != r_e2) begin
            w_pre = cpfcd_pkg::ST_MISMATCH;
        end else begin
            w_pre = cpfcd_pkg::ST_OK;
        end
        o_job.id         = r_id;
        o_job.slot_idx   = r_slot_idx;
        o_job.slot_ok    = r_slot_ok;
        o_job.cnt        = r_cnt;
        o_job.e1         = r_e1;
        o_job.e2         = r_e2;
        o_job.pre_status = w_pre;
    end

    a_push_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_state == cpfcd_pkg::F_IDLE))
        else $error("front did not return to idle after push");

    a_cnt_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cpfcd_pkg::F_PUSH) |-> (32'(r_cnt) <= cpfcd_pkg::TABLE_DEPTH))
        else $error("count above table depth");

endmodule

`default_nettype wire

### design/cpfcd_queue.sv
`default_nettype none

module cpfcd_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  cpfcd_pkg::t_job  i_job,
    output logic             o_full,
    input  wire              i_pop,
    output cpfcd_pkg::t_job  o_job,
    output logic             o_empty
);

    cpfcd_pkg::t_job r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_fill;

    assign o_full  = (r_fill == 2'd2);
    assign o_empty = (r_fill == 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    // Hold payload entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

### design/cpfcd_back.sv
`default_nettype none

module cpfcd_back (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_q_empty,
    input  cpfcd_pkg::t_job                i_job,
    output logic                           o_pop,
    output logic                           o_valid,
    input  wire                            i_ready,
    output logic [cpfcd_pkg::M_DATA_W-1:0] o_data
);

    cpfcd_pkg::t_back_state r_state, n_state;

    cpfcd_pkg::t_job             r_job;
    logic [cpfcd_pkg::CNT_W-1:0] r_idx;
    logic                        r_chk_v;
    logic                        r_dup;
    logic [cpfcd_pkg::ID_W-1:0]  r_rd_data;
    logic                        r_m_valid;
    logic [cpfcd_pkg::M_DATA_W-1:0] r_m_data;

    logic [cpfcd_pkg::ID_W-1:0]  r_table [cpfcd_pkg::TABLE_DEPTH];

    logic                        w_rd_en;
    logic                        w_skip;
    logic                        w_load;
    logic                        w_scan_end;
    cpfcd_pkg::t_status          w_status;

    assign w_skip     = r_job.slot_ok && (r_idx[cpfcd_pkg::IDX_W-1:0] == r_job.slot_idx);
    assign w_scan_end = (r_idx == r_job.cnt) && !r_chk_v;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cpfcd_pkg::B_IDLE: if (!i_q_empty) n_state = cpfcd_pkg::B_SCAN;
            cpfcd_pkg::B_SCAN: if (w_scan_end) n_state = cpfcd_pkg::B_DONE;
            cpfcd_pkg::B_DONE: if (!r_m_valid || i_ready) n_state = cpfcd_pkg::B_IDLE;
            default:           n_state = cpfcd_pkg::B_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_pop   = 1'b0;
        w_rd_en = 1'b0;
        w_load  = 1'b0;
        case (r_state)
            cpfcd_pkg::B_IDLE: o_pop   = !i_q_empty;
            cpfcd_pkg::B_SCAN: w_rd_en = (r_idx != r_job.cnt);
            cpfcd_pkg::B_DONE: w_load  = !r_m_valid || i_ready;
            default: begin
                o_pop   = 1'b0;
                w_rd_en = 1'b0;
                w_load  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cpfcd_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ID table: write the candidate on pop, read one entry per scan cycle
    always_ff @(posedge i_clk) begin
        if (o_pop && i_job.slot_ok) begin
            r_table[i_job.slot_idx] <= i_job.id;
        end
        if (w_rd_en) begin
            r_rd_data <= r_table[r_idx[cpfcd_pkg::IDX_W-1:0]];
        end
    end

    // Hold the working request and walk the table
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_chk_v <= 1'b0;
            r_dup   <= 1'b0;
        end else begin
            r_chk_v <= w_rd_en && !w_skip;
            if (o_pop) begin
                r_idx <= '0;
                r_dup <= 1'b0;
            end else begin
                if (w_rd_en) begin
                    r_idx <= r_idx + cpfcd_pkg::CNT_W'(1);
                end
                if (r_chk_v && (r_rd_data == r_job.id)) begin
                    r_dup <= 1'b1;
                end
            end
        end
    end

    assign w_status = r_dup ? cpfcd_pkg::ST_DUP : r_job.pre_status;

    // Output register toward the master side
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_m_data <= {6'd0, r_job.e2, r_job.e1, w_status};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load) begin
            r_m_valid <= 1'b1;
        end else if (i_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    assign o_valid = r_m_valid;
    assign o_data  = r_m_data;

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cpfcd_pkg::B_SCAN) |-> (r_idx <= r_job.cnt))
        else $error("scan index past count");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_m_valid || i_ready))
        else $error("result overwritten before taken");

endmodule

`default_nettype wire

### design/cpf_check_and_duplicate_table.sv
// Flow: the classifier (states FIRST, SECOND, PUSH) works out the check digits and pushes into a
//   two-entry queue; the table scanner pops it, reads entries 0 to n-1 one entry per cycle, where
//   n = min(registered_count, 64), and registers the result. The classifier takes the next request
//   meanwhile; a full queue or a stalled result side holds the flow.
// Reset: synchronous, active low; clears all control state. Table contents are undefined until
//   written, and no clearing pass runs.
`default_nettype none

module cpf_check_and_duplicate_table (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    // [43:0] id_digits, [49:44] slot, [56:50] registered_count, [63:57] zero
    input  wire [cpfcd_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // [0] func (only store and check exists; both codes act alike)
    input  wire                            s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    // [1:0] status, [5:2] expected_first, [9:6] expected_second, [15:10] zero
    output logic [cpfcd_pkg::M_DATA_W-1:0] m_axis_tdata
);

    logic            w_push;
    logic            w_pop;
    logic            w_q_full;
    logic            w_q_empty;
    logic            w_in_valid;
    cpfcd_pkg::t_job w_push_job;
    cpfcd_pkg::t_job w_pop_job;

    // The selector carries no behavior: every request stores and checks
    assign w_in_valid = s_axis_tvalid && (s_axis_tuser || !s_axis_tuser);

    cpfcd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_in_valid),
        .o_ready  (s_axis_tready),
        .i_id     (s_axis_tdata[43:0]),
        .i_slot   (s_axis_tdata[49:44]),
        .i_count  (s_axis_tdata[56:50]),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_job    (w_push_job)
    );

    cpfcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_empty (w_q_empty)
    );

    cpfcd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_job     (w_pop_job),
        .o_pop     (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata)
    );

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import cpfcd_pkg::*;

    localparam int N_RANDOM     = 1850;
    localparam int CALM_TAIL    = 150;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int DRAIN_CYCLES = 100;
    localparam int MAX_COUNT    = 127;
    localparam int MAX_SHOWN    = 10;

    typedef struct {
        logic              func;
        logic [ID_W-1:0]   id;
        logic [SLOT_W-1:0] slot;
        logic [RCNT_W-1:0] cnt;
    } id_req_t;

    typedef struct {
        t_status    status;
        logic [3:0] first;
        logic [3:0] second;
    } verdict_t;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // [43:0] id_digits, [49:44] slot, [56:50] registered_count, [63:57] zero
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    // [0] func
    logic                s_axis_tuser  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // [1:0] status, [5:2] expected_first, [9:6] expected_second, [15:10] zero
    logic [M_DATA_W-1:0] m_axis_tdata;

    cpf_check_and_duplicate_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    id_req_t         id_requests[$];
    verdict_t        verdicts_due[$];
    // predictor copy of the ID table
    logic [ID_W-1:0] shadow_table [TABLE_DEPTH];
    // stimulus-side view of what each slot holds
    logic [ID_W-1:0] issued_ids [TABLE_DEPTH];
    bit              slot_filled [TABLE_DEPTH];

    int       n_total;
    int       n_sent;
    int       n_checked;
    int       n_errors;
    int       n_wide;
    int       cycles;
    int       status_seen [4];
    bit       tx_busy;
    bit       calm;
    int       tx_gap;
    int       rx_stall;
    id_req_t  cur_req;
    verdict_t got;
    verdict_t want;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     verdicts_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // 11 minus (sum mod 11), folding 10 and 11 to zero
    function automatic logic [3:0] fold11(input int s);
        int d;
        d = 11 - (s % 11);
        return (d >= 10) ? 4'd0 : 4'(d);
    endfunction

    function automatic void cpf_checks(input logic [ID_W-1:0] id,
                                       output logic [3:0] d1, output logic [3:0] d2);
        int s1;
        int s2;
        int i;
        int nib;
        s1 = 0;
        s2 = 0;
        for (i = 0; i < 9; i++) begin
            nib = id[4*(10-i) +: 4];
            s1 += nib * (10 - i);
            s2 += nib * (11 - i);
        end
        d1 = fold11(s1);
        d2 = fold11(s2 + 2 * d1);
    endfunction

    // Store the candidate, search the table, then grade the check digits
    task automatic judge_id(input id_req_t r);
        int         lim;
        int         i;
        bit         dup;
        bit         bad;
        logic [3:0] e1;
        logic [3:0] e2;
        verdict_t   v;
        lim = (r.cnt > TABLE_DEPTH) ? TABLE_DEPTH : r.cnt;
        // a 6-bit slot is always inside the table
        shadow_table[r.slot] = r.id;
        dup = 1'b0;
        for (i = 0; i < lim; i++) begin
            if (i != r.slot && shadow_table[i] == r.id) dup = 1'b1;
        end
        bad = 1'b0;
        for (i = 0; i < ID_NIBBLES; i++) begin
            if (r.id[4*i +: 4] > 4'd9) bad = 1'b1;
        end
        cpf_checks(r.id, e1, e2);
        if (dup) v.status = ST_DUP;
        else if (bad) v.status = ST_BAD;
        else if (r.id[7:4] != e1 || r.id[3:0] != e2) v.status = ST_MISMATCH;
        else v.status = ST_OK;
        v.first  = e1;
        v.second = e2;
        verdicts_due.push_back(v);
        status_seen[v.status]++;
        if (r.cnt > TABLE_DEPTH) n_wide++;
    endtask

    function automatic logic [ID_W-1:0] random_digits();
        logic [ID_W-1:0] id;
        int              i;
        for (i = 0; i < ID_NIBBLES; i++) id[4*i +: 4] = 4'($urandom_range(0, 9));
        return id;
    endfunction

    function automatic logic [ID_W-1:0] with_checks(input logic [ID_W-1:0] id);
        logic [3:0]      d1;
        logic [3:0]      d2;
        logic [ID_W-1:0] r;
        cpf_checks(id, d1, d2);
        r      = id;
        r[7:4] = d1;
        r[3:0] = d2;
        return r;
    endfunction

    // Lowest slot never written, apart from the one being stored now
    function automatic int first_empty(input int skip);
        int i;
        for (i = 0; i < TABLE_DEPTH; i++) begin
            if (!slot_filled[i] && i != skip) return i;
        end
        return TABLE_DEPTH;
    endfunction

    task automatic queue_request(input bit func, input logic [ID_W-1:0] id,
                                 input int slot, input int cnt);
        id_req_t r;
        r.func = func;
        r.id   = id;
        r.slot = SLOT_W'(slot);
        r.cnt  = RCNT_W'(cnt);
        slot_filled[slot] = 1'b1;
        issued_ids[slot]  = id;
        id_requests.push_back(r);
    endtask

    // Hold a request until taken and predict it on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            judge_id(cur_req);
            tx_busy = 1'b0;
            n_sent++;
        end
    end

    always @(negedge i_clk) begin
        calm = (n_sent >= n_total - CALM_TAIL);
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!tx_busy) begin
            if (tx_gap > 0) begin
                s_axis_tvalid <= 1'b0;
                tx_gap--;
            end else if (id_requests.size() > 0) begin
                cur_req = id_requests.pop_front();
                s_axis_tdata  <= S_DATA_W'({cur_req.cnt, cur_req.slot, cur_req.id});
                s_axis_tuser  <= cur_req.func;
                s_axis_tvalid <= 1'b1;
                tx_busy = 1'b1;
                if (!calm && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 13);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Stall the result side in bursts
    always @(negedge i_clk) begin
        if (rx_stall > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall--;
        end else begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0) rx_stall = $urandom_range(1, 13);
        end
    end

    task automatic note_error(input string msg);
        n_errors++;
        if (n_errors <= MAX_SHOWN) $display("%s", msg);
    endtask

    // Compare each result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = t_status'(m_axis_tdata[1:0]);
            got.first  = m_axis_tdata[5:2];
            got.second = m_axis_tdata[9:6];
            if (verdicts_due.size() == 0) begin
                note_error($sformatf("unexpected result %s %0d %0d", got.status.name(),
                                     got.first, got.second));
            end else begin
                want = verdicts_due.pop_front();
                if (got.status != want.status || got.first != want.first ||
                    got.second != want.second) begin
                    note_error($sformatf("result %0d: want %s %0d %0d, got %s %0d %0d",
                                         n_checked, want.status.name(), want.first,
                                         want.second, got.status.name(), got.first,
                                         got.second));
                end
            end
            n_checked++;
        end
    end

    initial begin : stimulus
        int              k;
        int              slot;
        int              lim;
        int              cnt;
        int              j;
        int              pos;
        logic [ID_W-1:0] id;

        // Directed: extremes, each status, own-slot skip, selector, precedence
        queue_request(0, '0, 0, 0);
        queue_request(0, '0, 1, 2);
        queue_request(0, {ID_W{1'b1}}, 2, 3);
        queue_request(0, 44'h52998224725, 3, 4);
        queue_request(0, 44'h52998224726, 4, 5);
        queue_request(0, 44'h52998224725, 5, 6);
        queue_request(0, 44'h99999999999, 6, 7);
        queue_request(0, 44'h99999999999, 6, 7);
        queue_request(1, 44'h11144477735, 7, 8);
        queue_request(0, {ID_W{1'b1}}, 8, 9);
        queue_request(0, 44'hA0000000000, 9, 10);
        queue_request(0, 44'h0000000000F, 10, 11);
        queue_request(0, 44'h99999999990, 11, 12);
        queue_request(1, 44'h52998224725, 63, 0);
        queue_request(0, 44'h52998224725, 12, 13);

        // Random: grow the table, then search it at every depth
        for (k = 0; k < N_RANDOM; k++) begin
            if (first_empty(-1) < TABLE_DEPTH && $urandom_range(0, 1)) slot = first_empty(-1);
            else slot = $urandom_range(0, TABLE_DEPTH - 1);
            lim = first_empty(slot);
            if (lim == TABLE_DEPTH) begin
                case ($urandom_range(0, 3))
                    0: cnt = $urandom_range(TABLE_DEPTH + 1, MAX_COUNT);
                    1: cnt = $urandom_range(TABLE_DEPTH - 1, TABLE_DEPTH);
                    default: cnt = $urandom_range(0, TABLE_DEPTH);
                endcase
            end else begin
                cnt = $urandom_range(0, 2) ? lim : $urandom_range(0, lim);
            end
            id = with_checks(random_digits());
            case ($urandom_range(0, 9))
                4, 5: begin
                    // copy an entry the search will reach
                    if (cnt > 0) begin
                        j = $urandom_range(0, ((cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt) - 1);
                        if (j != slot && slot_filled[j]) id = issued_ids[j];
                    end
                end
                6: begin
                    pos = $urandom_range(0, 1);
                    id[4*pos +: 4] = 4'((id[4*pos +: 4] + $urandom_range(1, 9)) % 10);
                end
                7: id[4*$urandom_range(0, ID_NIBBLES - 1) +: 4] = 4'($urandom_range(10, 15));
                8: id = ID_W'({$urandom(), $urandom()});
                9: id = random_digits();
                default: ;
            endcase
            queue_request($urandom_range(0, 1), id, slot, cnt);
        end
        n_total = id_requests.size();

        // Hold reset, then release it on a falling edge
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Drain, then allow trailing results to surface
        while (id_requests.size() > 0 || tx_busy || verdicts_due.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests, %0d results: %0d accepted, %0d duplicate, %0d mismatch,",
                 n_sent, n_checked, status_seen[ST_OK], status_seen[ST_DUP],
                 status_seen[ST_MISMATCH]);
        $display("%0d bad digit; %0d searches with saturated count; %0d errors in %0d cycles",
                 status_seen[ST_BAD], n_wide, n_errors, cycles);
        if (n_errors == 0 && verdicts_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
